// File: rtl/brb_pkg.sv
package brb_pkg;

   localparam int RING_DEPTH    = 16;
   localparam int MAX_CONSUMERS = 8;
   localparam int DATA_WIDTH    = 32;

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int ID_W   = $clog2(MAX_CONSUMERS);
   localparam int IDX_W  = 32;
   localparam int CNT_W  = 4;
   localparam int STAT_W = 2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_FETCH  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_INSERTED    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INSERT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FETCHED     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FETCH_EMPTY = 2'd3;

   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_CONSUMERS);

   typedef enum logic {
      ST_IDLE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              slot_freed;
      logic              caught_up;
      logic              fetched;
   } step_type;

endpackage

// File: rtl/broadcast_ring_buffer.sv
// Result path: an accepted item's step is held in pend_ff and loaded into the
//   result registers when the result side is free; no new item is taken until
//   then. The slot payload memory (one port, registered read) is accessed at
//   accept and its read data is captured into the result registers on that load.
// Reset: synchronous; all slots empty, all indices zero, consumer_count is 1.
// No clearing pass: slot state lives in flip-flops, payload only behind valid.
module broadcast_ring_buffer
   import brb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [ID_W-1:0]       req_consumer_id,
   input  logic [DATA_WIDTH-1:0] req_data_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_data_out,
   output logic                  rsp_slot_freed,
   output logic                  rsp_caught_up,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_consumer_count
);

   state_type state_ff;
   state_type state_in;

   logic [CNT_W-1:0]      count_ff;
   step_type              step;
   step_type              pend_ff;
   logic                  accept;
   logic                  load_out;
   logic                  ram_we;
   logic                  ram_re;
   logic [SLOT_W-1:0]     ram_addr;
   logic [DATA_WIDTH-1:0] ram_rdata;

   logic                  rsp_valid_ff;
   logic [STAT_W-1:0]     rsp_status_ff;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   logic                  rsp_freed_ff;
   logic                  rsp_caught_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_RESET;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_consumer_count;
      end
   end

   brb_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step_en        (accept),
      .cmd            (req_cmd),
      .consumer_id    (req_consumer_id),
      .consumer_count (count_ff),
      .step           (step),
      .ram_we         (ram_we),
      .ram_re         (ram_re),
      .ram_addr       (ram_addr)
   );

   brb_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (RING_DEPTH)
   ) u_payload (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (req_data_in),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DONE: load_out  = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            load_out  = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_status_ff <= pend_ff.status;
         rsp_data_ff   <= pend_ff.fetched ? ram_rdata : '0;
         rsp_freed_ff  <= pend_ff.slot_freed;
         rsp_caught_ff <= pend_ff.caught_up;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_slot_freed = rsp_freed_ff;
   assign rsp_caught_up  = rsp_caught_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("item accepted while another is in flight");

   a_data_only_fetched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_FETCHED || rsp_data_out == '0))
      else $error("payload on a result that is not a fetch");

   a_freed_only_fetched: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_slot_freed) |-> (rsp_status == STAT_FETCHED))
      else $error("slot freed without a fetch");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid)
      else $error("result load lost");

endmodule

// File: rtl/brb_ram.sv
module brb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/brb_core.sv
module brb_core
   import brb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic                  cmd,
   input  logic [ID_W-1:0]       consumer_id,
   input  logic [CNT_W-1:0]      consumer_count,
   output step_type              step,
   output logic                  ram_we,
   output logic                  ram_re,
   output logic [SLOT_W-1:0]     ram_addr
);

   logic [RING_DEPTH-1:0] valid_ff;
   logic [CNT_W-1:0]      readers_ff [RING_DEPTH];
   logic [IDX_W-1:0]      cidx_ff [MAX_CONSUMERS];
   logic [IDX_W-1:0]      prod_ff;

   logic [CNT_W-1:0]  eff_count;
   logic [SLOT_W-1:0] p_slot;
   logic [SLOT_W-1:0] c_slot;
   logic [IDX_W-1:0]  c_idx;
   logic [CNT_W-1:0]  readers_cur;
   logic [CNT_W-1:0]  readers_dec;
   logic              ins_ok;
   logic              fetch_ok;
   logic [IDX_W-1:0]  prod_in;
   logic [IDX_W-1:0]  cidx_in;

   always_comb begin
      if (consumer_count == '0) begin
         eff_count = CNT_W'(1);
      end else if (consumer_count > CNT_MAX) begin
         eff_count = CNT_MAX;
      end else begin
         eff_count = consumer_count;
      end
   end

   assign p_slot      = prod_ff[SLOT_W-1:0];
   assign c_idx       = cidx_ff[consumer_id];
   assign c_slot      = c_idx[SLOT_W-1:0];
   assign readers_cur = readers_ff[c_slot];
   // saturate at zero
   assign readers_dec = (readers_cur != '0) ? readers_cur - CNT_W'(1) : '0;

   assign ins_ok   = (cmd == CMD_INSERT) && !valid_ff[p_slot];
   assign fetch_ok = (cmd == CMD_FETCH) && (CNT_W'(consumer_id) < eff_count)
                     && (c_idx != prod_ff) && valid_ff[c_slot];

   assign prod_in = prod_ff + IDX_W'(ins_ok);
   assign cidx_in = c_idx + IDX_W'(fetch_ok);

   always_comb begin
      if (cmd == CMD_INSERT) begin
         step.status = ins_ok ? STAT_INSERTED : STAT_INSERT_FULL;
      end else begin
         step.status = fetch_ok ? STAT_FETCHED : STAT_FETCH_EMPTY;
      end
      step.slot_freed = fetch_ok && (readers_dec == '0);
      step.caught_up  = (cidx_in == prod_in);
      step.fetched    = fetch_ok;
   end

   assign ram_we   = step_en && ins_ok;
   assign ram_re   = step_en && fetch_ok;
   assign ram_addr = (cmd == CMD_INSERT) ? p_slot : c_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         prod_ff  <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            readers_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_CONSUMERS; i++) begin
            cidx_ff[i] <= '0;
         end
      end else if (step_en) begin
         if (ins_ok) begin
            valid_ff[p_slot]   <= 1'b1;
            readers_ff[p_slot] <= eff_count;
            prod_ff            <= prod_in;
         end
         if (fetch_ok) begin
            cidx_ff[consumer_id] <= cidx_in;
            readers_ff[c_slot]   <= readers_dec;
            // last reader releases the slot
            if (readers_dec == '0) begin
               valid_ff[c_slot] <= 1'b0;
            end
         end
      end
   end

endmodule
